### rtl/ssfi_pkg.sv
// Shared types and constants for the sensor sample fault injector.
// No dependencies; every other file of the block imports this package.
package ssfi_pkg;

  // Height samples are carried at a fixed width throughout the block.
  localparam int HeightW    = 32;
  localparam int TimeW      = 32;
  localparam int AmpW       = 20;
  localparam int RunLenW    = 16;
  localparam int RateW      = 24;
  localparam int LimitW     = 31;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 31;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgIdxMode   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxAmp    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxRunLen = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxRate   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxLimit  = 3'd4;

  typedef enum logic [2:0] {
    MODE_SPIKE      = 3'd0,
    MODE_BURST      = 3'd1,
    MODE_DROPOUT    = 3'd2,
    MODE_STUCK      = 3'd3,
    MODE_DRIFT      = 3'd4,
    MODE_SATURATION = 3'd5,
    MODE_STALL      = 3'd6,
    MODE_PASS       = 3'd7
  } fault_mode_e;

  typedef struct packed {
    logic signed [HeightW-1:0] height_in;
    logic [TimeW-1:0]          elapsed_time;
    logic                      trigger_hit;
    logic                      sign_positive;
  } sample_in_t;

  typedef struct packed {
    logic signed [HeightW-1:0] height_out;
    logic                      height_valid;
    logic                      stage_stall;
  } sample_out_t;

  typedef struct packed {
    fault_mode_e               fault_mode;
    logic [AmpW-1:0]           spike_amplitude;
    logic [RunLenW-1:0]        run_length;
    logic signed [RateW-1:0]   drift_rate;
    logic [LimitW-1:0]         saturation_limit;
  } cfg_t;

  // Run controller status toward the mode datapath.
  typedef struct packed {
    logic                      active;
    logic signed [HeightW-1:0] held;
  } run_status_t;

endpackage

### rtl/ssfi_cfg_regs.sv
// Configuration register file of the fault injector.
// Depends on ssfi_pkg for the register indexes and the cfg_t layout.
module ssfi_cfg_regs
  import ssfi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxMode:   cfg_d.fault_mode       = fault_mode_e'(cfg_wdata_i[2:0]);
        CfgIdxAmp:    cfg_d.spike_amplitude  = cfg_wdata_i[AmpW-1:0];
        CfgIdxRunLen: cfg_d.run_length       = cfg_wdata_i[RunLenW-1:0];
        CfgIdxRate:   cfg_d.drift_rate       = $signed(cfg_wdata_i[RateW-1:0]);
        CfgIdxLimit:  cfg_d.saturation_limit = cfg_wdata_i[LimitW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fault_mode       <= MODE_PASS;
      cfg_q.spike_amplitude  <= '0;
      cfg_q.run_length       <= RunLenW'(1);
      cfg_q.drift_rate       <= '0;
      cfg_q.saturation_limit <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/ssfi_run_ctrl.sv
// Run counter and held height for the burst, dropout and stuck modes.
// Depends on ssfi_pkg for fault_mode_e and run_status_t.
module ssfi_run_ctrl
  import ssfi_pkg::*;
#(
  parameter int RunCountW = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  fault_mode_e               mode_i,
  input  logic                      trig_i,
  input  logic signed [HeightW-1:0] height_i,
  input  logic [RunLenW-1:0]        run_len_i,
  output run_status_t               status_o
);

  localparam int LoadW = (RunCountW > RunLenW) ? RunCountW : RunLenW;
  localparam logic [LoadW-1:0] CountMax = LoadW'((64'd1 << RunCountW) - 64'd1);

  logic [RunCountW-1:0]      run_q, run_d, cnt, load;
  logic signed [HeightW-1:0] held_q, held_d;
  logic [LoadW-1:0]          len_ext, len_sat;
  logic                      run_mode, start, active;

  always_comb begin
    len_ext = LoadW'(run_len_i);
    if (len_ext == '0) begin
      len_sat = LoadW'(1);
    end else if (len_ext > CountMax) begin
      len_sat = CountMax;
    end else begin
      len_sat = len_ext;
    end
    load = len_sat[RunCountW-1:0];

    run_mode = (mode_i == MODE_BURST) || (mode_i == MODE_DROPOUT) ||
               (mode_i == MODE_STUCK);
    start    = run_mode && (run_q == '0) && trig_i;
    cnt      = start ? load : run_q;
    active   = run_mode && (cnt != '0);
    run_d    = active ? cnt - RunCountW'(1) : run_q;
    held_d   = (start && (mode_i == MODE_STUCK)) ? height_i : held_q;

    status_o.active = active;
    status_o.held   = held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      held_q <= '0;
    end else if (adv_i) begin
      run_q  <= run_d;
      held_q <= held_d;
    end
  end

endmodule

### rtl/ssfi_result_stage.sv
// Final add, rounding shift and height saturation, plus the output register.
// Depends on ssfi_pkg for sample_out_t and the height width.
module ssfi_result_stage
  import ssfi_pkg::*;
#(
  parameter int AccW      = 58,
  parameter int FracBits  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [AccW-1:0] base_i,
  input  logic signed [AccW-1:0] addend_i,
  input  logic                   hvalid_i,
  input  logic                   hstall_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output sample_out_t            out_data_o
);

  localparam logic signed [AccW-1:0] HMax =
    AccW'((65'sd1 <<< (HeightW - 1)) - 65'sd1);
  localparam logic signed [AccW-1:0] HMin = -HMax - AccW'(1);

  logic signed [AccW-1:0] sum, shifted;
  sample_out_t            res_d, res_q;
  logic                   valid_q, load;

  // In drift mode the low fraction bits of base hold the rounding half, so the
  // arithmetic shift floors to the nearest value with ties going up.
  always_comb begin
    sum     = base_i + addend_i;
    shifted = sum >>> FracBits;
    if (shifted > HMax) begin
      res_d.height_out = HMax[HeightW-1:0];
    end else if (shifted < HMin) begin
      res_d.height_out = HMin[HeightW-1:0];
    end else begin
      res_d.height_out = shifted[HeightW-1:0];
    end
    res_d.height_valid = hvalid_i;
    res_d.stage_stall  = hstall_i;
  end

  assign ready_o = !valid_q || !out_stall_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

endmodule

### rtl/sensor_sample_fault_injector.sv
// Top level of the sensor sample fault injector: input register, mode datapath,
// drift multiplier and pipeline control. Depends on ssfi_pkg, ssfi_cfg_regs,
// ssfi_run_ctrl and ssfi_result_stage.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-------------------------
//   in      | into      | in_valid_i / in_stall_o | in_data_i  (sample_in_t)
//   out     | out of    | out_valid_o / out_stall_i | out_data_o (sample_out_t)
//   cfg     | into      | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One transfer is accepted every cycle while no stall holds the pipeline; each
// sample passes in turn through the input register, mode/multiply stage and output register.
// The drift multiplier (24 by 33 bits) sets the critical path of the middle
// stage; the final add and saturation set that of the last stage.
// Reset clears all valid bits, the run counter, the held height and the
// configuration registers to their documented reset values.
// A stall reaches the input in the same cycle: the middle register moves only
// when the output register is empty or hands on its transfer, and the input
// register takes a new transfer when it is empty or when it moves on.
module sensor_sample_fault_injector
  import ssfi_pkg::*;
#(
  parameter int RUN_COUNT_WIDTH = 16,
  parameter int TIME_FRAC_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sample_in_t          in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sample_out_t         out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // The product of the signed rate and the unsigned time needs RateW + TimeW + 1
  // bits; the shifted height needs HeightW + TIME_FRAC_BITS. One more bit keeps
  // the final sum from overflowing.
  localparam int ProdW = RateW + TimeW + 1;
  localparam int ShW   = HeightW + TIME_FRAC_BITS;
  localparam int AccW  = ((ProdW > ShW) ? ProdW : ShW) + 1;
  localparam logic signed [AccW-1:0] HalfLsb =
    (AccW'(1) <<< TIME_FRAC_BITS) >>> 1;

  cfg_t        cfg;
  run_status_t run_st;

  // Input register.
  sample_in_t s1_q;
  logic       s1_valid_q, s1_ready, s1_adv, in_accept;

  // Middle register between the mode datapath and the result stage.
  logic signed [AccW-1:0] base_d, base_q, addend_d, addend_q;
  logic                   hvalid_d, hvalid_q, hstall_d, hstall_q;
  logic                   s2_valid_q, s2_ready;

  logic signed [ProdW-1:0]   product;
  logic signed [AmpW:0]      amp_s;
  logic signed [HeightW-1:0] lim_s, clamped;

  ssfi_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ssfi_run_ctrl #(
    .RunCountW (RUN_COUNT_WIDTH)
  ) u_run (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (s1_adv),
    .mode_i    (cfg.fault_mode),
    .trig_i    (s1_q.trigger_hit),
    .height_i  (s1_q.height_in),
    .run_len_i (cfg.run_length),
    .status_o  (run_st)
  );

  // Handshake chain: the input register is ready when empty or when it drains;
  // the middle register moves only when the output register can take it.
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s1_adv     = s1_valid_q && s2_ready;
  assign in_accept  = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_data_i;
    end
  end

  // Mode datapath. Every height is carried with TIME_FRAC_BITS fraction bits
  // so that drift and the other modes share one add, one shift and one
  // saturation in the result stage.
  always_comb begin
    product = cfg.drift_rate * $signed({1'b0, s1_q.elapsed_time});
    amp_s   = s1_q.sign_positive ? $signed({1'b0, cfg.spike_amplitude})
                                 : -$signed({1'b0, cfg.spike_amplitude});
    lim_s   = $signed(HeightW'(cfg.saturation_limit));
    if (s1_q.height_in > lim_s) begin
      clamped = lim_s;
    end else if (s1_q.height_in < -lim_s) begin
      clamped = -lim_s;
    end else begin
      clamped = s1_q.height_in;
    end

    base_d   = AccW'(s1_q.height_in) <<< TIME_FRAC_BITS;
    addend_d = '0;
    hvalid_d = 1'b1;
    hstall_d = 1'b0;

    unique case (cfg.fault_mode)
      MODE_SPIKE: begin
        if (s1_q.trigger_hit) begin
          addend_d = AccW'(amp_s) <<< TIME_FRAC_BITS;
        end
      end
      MODE_BURST: begin
        if (run_st.active) begin
          addend_d = AccW'(amp_s) <<< TIME_FRAC_BITS;
        end
      end
      MODE_DROPOUT: begin
        if (run_st.active) begin
          base_d   = '0;
          hvalid_d = 1'b0;
        end
      end
      MODE_STUCK: begin
        if (run_st.active) begin
          base_d = AccW'(run_st.held) <<< TIME_FRAC_BITS;
        end
      end
      MODE_DRIFT: begin
        // The shifted height has zero fraction bits, so OR-ing in the half
        // adds the rounding offset.
        base_d   = base_d | HalfLsb;
        addend_d = AccW'(product);
      end
      MODE_SATURATION: begin
        base_d = AccW'(clamped) <<< TIME_FRAC_BITS;
      end
      MODE_STALL: begin
        hstall_d = s1_q.trigger_hit;
      end
      MODE_PASS: begin
        base_d = AccW'(s1_q.height_in) <<< TIME_FRAC_BITS;
      end
      default: begin
        base_d = AccW'(s1_q.height_in) <<< TIME_FRAC_BITS;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      base_q   <= base_d;
      addend_q <= addend_d;
      hvalid_q <= hvalid_d;
      hstall_q <= hstall_d;
    end
  end

  ssfi_result_stage #(
    .AccW     (AccW),
    .FracBits (TIME_FRAC_BITS)
  ) u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s2_valid_q),
    .ready_o     (s2_ready),
    .base_i      (base_q),
    .addend_i    (addend_q),
    .hvalid_i    (hvalid_q),
    .hstall_i    (hstall_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
